### design/cpmp_pkg.sv
// Shared types, constants and helpers for the cascaded PID motor position controller.
`timescale 1ns / 1ps

package cpmp_pkg;

    localparam int NUM_STAGES = 11;

    // Register map of the configuration port
    typedef enum logic [2:0] {
        REG_ANGLE_SETPOINT = 3'd0,
        REG_SPEED_CAP      = 3'd1,
        REG_SPEED_KP       = 3'd2,
        REG_SPEED_KI       = 3'd3,
        REG_SPEED_KD       = 3'd4,
        REG_POSITION_KP    = 3'd5,
        REG_POSITION_KI    = 3'd6,
        REG_POSITION_KD    = 3'd7
    } cfg_reg_t;

    // 0.01 s in Q0.24
    localparam logic [17:0]        DT_Q24         = 18'd167772;
    localparam logic signed [23:0] POS_SUM_MAX    = 24'sd5120000;          // 20000 in Q.8
    localparam logic signed [39:0] SPD_SUM_MAX    = 40'sd335544320000;     // 20000 in Q.24
    localparam logic signed [63:0] DUTY_LIMIT_Q32 = 64'sd42949672960000;   // 10000 in Q.32
    localparam logic [13:0]        DUTY_FULL      = 14'd10000;
    localparam logic signed [28:0] CMD_RESET      = 29'sd22937600;         // 350.0 in Q12.16

    localparam logic [31:0] ANGLE_SETPOINT_RESET = 32'd0;
    localparam logic [11:0] SPEED_CAP_RESET      = 12'd350;
    localparam logic [23:0] SPEED_KP_RESET       = 24'd65536;
    localparam logic [23:0] SPEED_KI_RESET       = 24'd3277;
    localparam logic [23:0] SPEED_KD_RESET       = 24'd13107;
    localparam logic [23:0] POS_KP_RESET         = 24'd163840;
    localparam logic [23:0] POS_KI_RESET         = 24'd131;
    localparam logic [23:0] POS_KD_RESET         = 24'd5898;

    typedef struct packed {
        logic [23:0] kp;
        logic [23:0] ki;
        logic [23:0] kd;
    } pid_gains_t;

    // load: stage register takes new contents; fire: a valid beat enters the stage
    typedef struct packed {
        logic [NUM_STAGES:1] load;
        logic [NUM_STAGES:1] fire;
    } pipe_ctrl_t;

    // x * 100 as shift-add
    function automatic logic signed [63:0] mul100(input logic signed [63:0] x);
        return (x <<< 6) + (x <<< 5) + (x <<< 2);
    endfunction

endpackage

### design/cpmp_pos_loop.sv
// Position PID pipeline: angle error in, commanded speed out (stages 1 to 6).
`timescale 1ns / 1ps

module cpmp_pos_loop (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cpmp_pkg::pipe_ctrl_t       ctrl,
    input  logic signed [31:0]         angle_setpoint,
    input  logic [11:0]                speed_cap,
    input  cpmp_pkg::pid_gains_t       gains,
    input  logic signed [28:0]         measured_speed,
    input  logic signed [31:0]         measured_angle,
    output logic signed [28:0]         speed5,
    output logic signed [31:0]         error5,
    output logic signed [28:0]         cmd
);

    logic signed [31:0] ep1_reg, ep2_reg, ep3_reg, ep4_reg, ep5_reg;
    logic signed [28:0] ms1_reg, ms2_reg, ms3_reg, ms4_reg, ms5_reg;
    logic signed [50:0] dt2_reg;
    logic signed [56:0] kpe2_reg, kpe3_reg, kpe4_reg;
    logic signed [32:0] diff2_reg;
    logic signed [31:0] last_reg;
    logic signed [23:0] sum_reg, sum3_reg;
    logic signed [57:0] kdd3_reg;
    logic signed [48:0] kis4_reg;
    logic signed [63:0] kdd4_reg;
    logic signed [63:0] acc5_reg;
    logic signed [28:0] cmd_reg;

    logic signed [35:0] sum_wide;
    logic signed [23:0] sum_next;
    logic signed [63:0] pos_lim;
    logic signed [63:0] neg_lim;
    logic signed [28:0] cmd_next;

    always_comb
    begin
        sum_wide = 36'(sum_reg) + 36'($signed(dt2_reg[50:16]));
        if (sum_wide > 36'(cpmp_pkg::POS_SUM_MAX))
        begin
            sum_next = cpmp_pkg::POS_SUM_MAX;
        end
        else if (sum_wide < -36'(cpmp_pkg::POS_SUM_MAX))
        begin
            sum_next = -cpmp_pkg::POS_SUM_MAX;
        end
        else
        begin
            sum_next = $signed(sum_wide[23:0]);
        end
    end

    always_comb
    begin
        pos_lim = $signed({36'd0, speed_cap, 16'd0});
        neg_lim = -pos_lim;
        if (acc5_reg > pos_lim)
        begin
            cmd_next = $signed(pos_lim[28:0]);
        end
        else if (acc5_reg < neg_lim)
        begin
            cmd_next = $signed(neg_lim[28:0]);
        end
        else
        begin
            cmd_next = $signed(acc5_reg[28:0]);
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (ctrl.load[1])
        begin
            ep1_reg <= angle_setpoint - measured_angle;
            ms1_reg <= measured_speed;
        end
        if (ctrl.load[2])
        begin
            dt2_reg   <= 51'(ep1_reg) * 51'($signed({1'b0, cpmp_pkg::DT_Q24}));
            kpe2_reg  <= 57'($signed({1'b0, gains.kp})) * 57'(ep1_reg);
            diff2_reg <= 33'(ep1_reg) - 33'(last_reg);
            ep2_reg   <= ep1_reg;
            ms2_reg   <= ms1_reg;
        end
        if (ctrl.load[3])
        begin
            sum3_reg <= sum_next;
            kdd3_reg <= 58'($signed({1'b0, gains.kd})) * 58'(diff2_reg);
            kpe3_reg <= kpe2_reg;
            ep3_reg  <= ep2_reg;
            ms3_reg  <= ms2_reg;
        end
        if (ctrl.load[4])
        begin
            kis4_reg <= 49'($signed({1'b0, gains.ki})) * 49'(sum3_reg);
            kdd4_reg <= cpmp_pkg::mul100(64'(kdd3_reg));
            kpe4_reg <= kpe3_reg;
            ep4_reg  <= ep3_reg;
            ms4_reg  <= ms3_reg;
        end
        if (ctrl.load[5])
        begin
            acc5_reg <= 64'(kpe4_reg) + 64'($signed(kis4_reg[48:8])) + kdd4_reg;
            ep5_reg  <= ep4_reg;
            ms5_reg  <= ms4_reg;
        end
    end

    // Loop state: each variable is read and written at one stage only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= '0;
            sum_reg  <= '0;
            cmd_reg  <= cpmp_pkg::CMD_RESET;
        end
        else
        begin
            if (ctrl.fire[2])
            begin
                last_reg <= ep1_reg;
            end
            if (ctrl.fire[3])
            begin
                sum_reg <= sum_next;
            end
            if (ctrl.fire[6])
            begin
                cmd_reg <= cmd_next;
            end
        end
    end

    assign speed5 = ms5_reg;
    assign error5 = ep5_reg;
    assign cmd    = cmd_reg;

    a_pos_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_reg <= cpmp_pkg::POS_SUM_MAX) && (sum_reg >= -cpmp_pkg::POS_SUM_MAX))
        else $error("position integral outside its clamp");

endmodule

### design/cpmp_spd_loop.sv
// Speed PID pipeline and duty split: commanded speed in, duties out (stages 6 to 11).
`timescale 1ns / 1ps

module cpmp_spd_loop (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cpmp_pkg::pipe_ctrl_t       ctrl,
    input  cpmp_pkg::pid_gains_t       gains,
    input  logic signed [28:0]         speed5,
    input  logic signed [31:0]         error5,
    input  logic signed [28:0]         cmd,
    output logic [13:0]                forward_duty,
    output logic [13:0]                reverse_duty,
    output logic signed [31:0]         position_error,
    output logic                       done_res
);

    logic signed [29:0] es6_reg;
    logic signed [31:0] ep6_reg, ep7_reg, ep8_reg, ep9_reg, ep10_reg, ep11_reg;
    logic signed [47:0] dt7_reg;
    logic signed [54:0] kpe7_reg, kpe8_reg, kpe9_reg;
    logic signed [30:0] diff7_reg;
    logic signed [29:0] last_reg;
    logic signed [39:0] sum_reg, sum8_reg;
    logic signed [55:0] kdd8_reg;
    logic signed [64:0] kis9_reg;
    logic signed [63:0] kdd9_reg;
    logic signed [63:0] acc10_reg;
    logic [13:0]        fwd_reg, rev_reg;
    logic               done_reg;

    logic signed [40:0] sum_wide;
    logic signed [39:0] sum_next;
    logic signed [63:0] neg_acc;
    logic [13:0]        fwd_next, rev_next;
    logic               done_next;

    always_comb
    begin
        sum_wide = 41'(sum_reg) + 41'($signed(dt7_reg[47:16]));
        if (sum_wide > 41'(cpmp_pkg::SPD_SUM_MAX))
        begin
            sum_next = cpmp_pkg::SPD_SUM_MAX;
        end
        else if (sum_wide < -41'(cpmp_pkg::SPD_SUM_MAX))
        begin
            sum_next = -cpmp_pkg::SPD_SUM_MAX;
        end
        else
        begin
            sum_next = $signed(sum_wide[39:0]);
        end
    end

    // Clamp, split by sign, truncate to whole duty units; zero error brakes
    always_comb
    begin
        neg_acc   = -acc10_reg;
        done_next = (ep10_reg == 32'sd0);
        fwd_next  = '0;
        rev_next  = '0;
        if (done_next)
        begin
            fwd_next = cpmp_pkg::DUTY_FULL;
            rev_next = cpmp_pkg::DUTY_FULL;
        end
        else if (acc10_reg > 64'sd0)
        begin
            if (acc10_reg >= cpmp_pkg::DUTY_LIMIT_Q32)
            begin
                fwd_next = cpmp_pkg::DUTY_FULL;
            end
            else
            begin
                fwd_next = acc10_reg[45:32];
            end
        end
        else
        begin
            if (neg_acc >= cpmp_pkg::DUTY_LIMIT_Q32)
            begin
                rev_next = cpmp_pkg::DUTY_FULL;
            end
            else
            begin
                rev_next = neg_acc[45:32];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[6])
        begin
            // cmd still holds the previous beat's value here
            es6_reg <= 30'(cmd) - 30'(speed5);
            ep6_reg <= error5;
        end
        if (ctrl.load[7])
        begin
            dt7_reg   <= 48'(es6_reg) * 48'($signed({1'b0, cpmp_pkg::DT_Q24}));
            kpe7_reg  <= 55'($signed({1'b0, gains.kp})) * 55'(es6_reg);
            diff7_reg <= 31'(es6_reg) - 31'(last_reg);
            ep7_reg   <= ep6_reg;
        end
        if (ctrl.load[8])
        begin
            sum8_reg <= sum_next;
            kdd8_reg <= 56'($signed({1'b0, gains.kd})) * 56'(diff7_reg);
            kpe8_reg <= kpe7_reg;
            ep8_reg  <= ep7_reg;
        end
        if (ctrl.load[9])
        begin
            kis9_reg <= 65'($signed({1'b0, gains.ki})) * 65'(sum8_reg);
            kdd9_reg <= cpmp_pkg::mul100(64'(kdd8_reg));
            kpe9_reg <= kpe8_reg;
            ep9_reg  <= ep8_reg;
        end
        if (ctrl.load[10])
        begin
            acc10_reg <= 64'(kpe9_reg) + 64'($signed(kis9_reg[64:8])) + kdd9_reg;
            ep10_reg  <= ep9_reg;
        end
        if (ctrl.load[11])
        begin
            fwd_reg  <= fwd_next;
            rev_reg  <= rev_next;
            done_reg <= done_next;
            ep11_reg <= ep10_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= '0;
            sum_reg  <= '0;
        end
        else
        begin
            if (ctrl.fire[7])
            begin
                last_reg <= es6_reg;
            end
            if (ctrl.fire[8])
            begin
                sum_reg <= sum_next;
            end
        end
    end

    assign forward_duty   = fwd_reg;
    assign reverse_duty   = rev_reg;
    assign position_error = ep11_reg;
    assign done_res       = done_reg;

    a_spd_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_reg <= cpmp_pkg::SPD_SUM_MAX) && (sum_reg >= -cpmp_pkg::SPD_SUM_MAX))
        else $error("speed integral outside its clamp");

endmodule

### design/cascaded_pid_motor_position.sv
// Top level of the cascaded position/speed PID motor controller.
// An accepted input beat passes through stages 1 to 11 in order before its result beat reaches the output.
// Throughput: one beat per cycle; the output register and every stage take a new beat
// whenever the stage ahead of them is empty or moving, so a held result stalls only a full pipe.
// Reset: registers return to their default gains, target 0, max speed 350; loop state clears
// to zero and the commanded speed starts at 350 deg/s.
`timescale 1ns / 1ps

module cascaded_pid_motor_position (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wen,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [28:0]  measured_speed,
    input  logic signed [31:0]  measured_angle,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [13:0]         forward_duty,
    output logic [13:0]         reverse_duty,
    output logic signed [31:0]  position_error,
    output logic                done_res
);

    localparam int NS = cpmp_pkg::NUM_STAGES;

    logic signed [31:0]    angle_setpoint_reg;
    logic [11:0]           speed_cap_reg;
    cpmp_pkg::pid_gains_t  spd_gains_reg;
    cpmp_pkg::pid_gains_t  pos_gains_reg;

    logic [NS:1]           valid_reg;
    logic [NS:1]           holes;
    logic [NS:1]           stage_en;
    logic [NS:1]           valid_in;
    cpmp_pkg::pipe_ctrl_t  ctrl;

    logic signed [28:0]    speed5;
    logic signed [31:0]    error5;
    logic signed [28:0]    cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_setpoint_reg <= cpmp_pkg::ANGLE_SETPOINT_RESET;
            speed_cap_reg      <= cpmp_pkg::SPEED_CAP_RESET;
            spd_gains_reg      <= '{kp: cpmp_pkg::SPEED_KP_RESET, ki: cpmp_pkg::SPEED_KI_RESET,
                                    kd: cpmp_pkg::SPEED_KD_RESET};
            pos_gains_reg      <= '{kp: cpmp_pkg::POS_KP_RESET, ki: cpmp_pkg::POS_KI_RESET,
                                    kd: cpmp_pkg::POS_KD_RESET};
        end
        else if (cfg_wen)
        begin
            case (cpmp_pkg::cfg_reg_t'(cfg_index))
                cpmp_pkg::REG_ANGLE_SETPOINT: angle_setpoint_reg <= $signed(cfg_data);
                cpmp_pkg::REG_SPEED_CAP:      speed_cap_reg      <= cfg_data[11:0];
                cpmp_pkg::REG_SPEED_KP:       spd_gains_reg.kp   <= cfg_data[23:0];
                cpmp_pkg::REG_SPEED_KI:       spd_gains_reg.ki   <= cfg_data[23:0];
                cpmp_pkg::REG_SPEED_KD:       spd_gains_reg.kd   <= cfg_data[23:0];
                cpmp_pkg::REG_POSITION_KP:    pos_gains_reg.kp   <= cfg_data[23:0];
                cpmp_pkg::REG_POSITION_KI:    pos_gains_reg.ki   <= cfg_data[23:0];
                cpmp_pkg::REG_POSITION_KD:    pos_gains_reg.kd   <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // A stage may advance when any stage from it to the output is empty or the output drains
    always_comb
    begin
        holes = ~valid_reg;
        for (int i = 1; i <= NS; i++)
        begin
            stage_en[i] = out_ready | (|(holes >> (i - 1)));
        end
        valid_in = {valid_reg[NS-1:1], in_valid};
        ctrl.load = stage_en;
        ctrl.fire = stage_en & valid_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 1; i <= NS; i++)
            begin
                if (stage_en[i])
                begin
                    valid_reg[i] <= valid_in[i];
                end
            end
        end
    end

    assign in_ready  = stage_en[1];
    assign out_valid = valid_reg[NS];

    cpmp_pos_loop u_pos (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .angle_setpoint (angle_setpoint_reg),
        .speed_cap      (speed_cap_reg),
        .gains          (pos_gains_reg),
        .measured_speed (measured_speed),
        .measured_angle (measured_angle),
        .speed5         (speed5),
        .error5         (error5),
        .cmd            (cmd)
    );

    cpmp_spd_loop u_spd (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .gains          (spd_gains_reg),
        .speed5         (speed5),
        .error5         (error5),
        .cmd            (cmd),
        .forward_duty   (forward_duty),
        .reverse_duty   (reverse_duty),
        .position_error (position_error),
        .done_res       (done_res)
    );

    a_brake_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |->
            (forward_duty == cpmp_pkg::DUTY_FULL) && (reverse_duty == cpmp_pkg::DUTY_FULL)
            && (position_error == 32'sd0))
        else $error("brake beat without full duties or with nonzero error");

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !done_res) |-> (forward_duty == 14'd0) || (reverse_duty == 14'd0))
        else $error("both duty channels driven outside brake");

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            (forward_duty <= cpmp_pkg::DUTY_FULL) && (reverse_duty <= cpmp_pkg::DUTY_FULL))
        else $error("duty above full scale");

    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (&valid_reg) && !out_ready)
        else $error("input blocked with room in the pipe");

endmodule
